@@ design/lazy_delete_priority_queue_unit_macros.svh @@
// Assertion macros for the lazy-deletion priority queue.
// Used by the top level; needs nothing else.
`ifndef LAZY_DELETE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define LAZY_DELETE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define LDPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldpq: same-cycle check failed");

// next-cycle implication
`define LDPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldpq: next-cycle check failed");

`endif

@@ design/ldpq_pkg.sv @@
// Package for the lazy-deletion priority queue: field widths, codes, defaults.
// No dependencies.
`timescale 1ns / 1ps

package ldpq_pkg;

   // default sizes
   localparam int MAX_ENTRIES_DEF   = 1024;
   localparam int HEAP_DEPTH_DEF    = 4096;
   localparam int PRIORITY_BITS_DEF = 8;

   // request / response field widths
   localparam int OP_W     = 2;
   localparam int ID_W     = 10;
   localparam int AMT_W    = 8;
   localparam int STATUS_W = 2;

   // retire adds this much; entries above the limit are dead
   localparam int RETIRE_ADD = 101;
   localparam int LIVE_LIMIT = 100;

   typedef enum logic [OP_W-1:0] {
      OP_ARRIVE   = 2'd0,
      OP_INCREASE = 2'd1,
      OP_RETIRE   = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_UNKNOWN   = 2'd2,
      ST_DUPLICATE = 2'd3
   } status_type;

endpackage

@@ design/ldpq_if.sv @@
// Request and response channel interfaces (valid/ready with payload).
// Depends on ldpq_pkg.
`timescale 1ns / 1ps

interface ldpq_req_if;
   logic                        valid;
   logic                        ready;
   logic [ldpq_pkg::OP_W-1:0]   op;
   logic [ldpq_pkg::ID_W-1:0]   entry_id;
   logic [ldpq_pkg::AMT_W-1:0]  amount;

   modport source (output valid, op, entry_id, amount, input ready);
   modport sink   (input valid, op, entry_id, amount, output ready);
endinterface

interface ldpq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          is_empty;
   logic [ldpq_pkg::ID_W-1:0]     top_entry;
   logic [ldpq_pkg::STATUS_W-1:0] status;

   modport source (output valid, is_empty, top_entry, status, input ready);
   modport sink   (input valid, is_empty, top_entry, status, output ready);
endinterface

@@ design/ldpq_entry_ram.sv @@
// Per-entry record memory: present flag, current priority, arrival number.
// One write port, one registered read port. No package dependency.
`timescale 1ns / 1ps

module ldpq_entry_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 20,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/ldpq_heap_ram.sv @@
// Heap slot memory: one write port, two registered read ports (both children).
// No package dependency.
`timescale 1ns / 1ps

module ldpq_heap_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 29,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr0,
   input  logic [ADDR_W-1:0] raddr1,
   output logic [WIDTH-1:0]  rdata0,
   output logic [WIDTH-1:0]  rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata0_ff;
   logic [WIDTH-1:0] rdata1_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // two registered reads
   always_ff @(posedge clock) begin
      rdata0_ff <= mem[raddr0];
      rdata1_ff <= mem[raddr1];
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

@@ design/lazy_delete_priority_queue_unit.sv @@
// A query goes straight to cleanup; any other in-range op first looks up its entry
// record, and a push then sifts up a level at a time until it stops or reaches
// the root. Cleanup reads the top; each dead top is popped and the last slot
// sifted down (unless that empties the heap) until the top is live or none is left.
// Throughput: one request at a time; the heap memory's read-compare-write walk
// sets the rate. Next request taken while a response still waits.
// Reset: synchronous; a clear pass zeroes every entry-table address, so the entry
// table is clear before the first request is taken. Heap contents need no clearing.
`timescale 1ns / 1ps
`include "lazy_delete_priority_queue_unit_macros.svh"

module lazy_delete_priority_queue_unit #(
   parameter int MAX_ENTRIES   = ldpq_pkg::MAX_ENTRIES_DEF,
   parameter int HEAP_DEPTH    = ldpq_pkg::HEAP_DEPTH_DEF,
   parameter int PRIORITY_BITS = ldpq_pkg::PRIORITY_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ldpq_req_if.sink     req_if,
   ldpq_rsp_if.source   rsp_if
);

   localparam int PB  = PRIORITY_BITS;
   localparam int EW  = $clog2(MAX_ENTRIES);
   localparam int AW  = EW + 1;
   localparam int HW  = $clog2(HEAP_DEPTH);
   localparam int CW  = HW + 1;
   localparam int SW  = ((PB > ldpq_pkg::AMT_W) ? PB : ldpq_pkg::AMT_W) + 1;
   localparam int EDW = 1 + PB + AW;
   localparam int SDW = PB + AW + EW;
   localparam int PRIO_MAX = (1 << PB) - 1;

   typedef struct packed {
      logic [PB-1:0] prio;
      logic [AW-1:0] arr;
      logic [EW-1:0] id;
   } slot_type;

   typedef struct packed {
      logic          present;
      logic [PB-1:0] prio;
      logic [AW-1:0] arr;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ECHK, S_PUSH_RD, S_PUSH_CMP, S_CLEAN, S_CL_TOP,
      S_CL_CHK, S_POP_LAST, S_POP_RD, S_POP_CMP, S_RESP
   } state_type;

   // a ranks strictly below b: lower priority, or equal and later arrival
   function automatic logic ranks_below(input slot_type a, input slot_type b);
      return (a.prio == b.prio) ? (a.arr > b.arr) : (a.prio < b.prio);
   endfunction

   state_type                    state_ff, state_in;
   logic [ldpq_pkg::OP_W-1:0]    op_ff, op_in;
   logic [EW-1:0]                id_ff, id_in;
   logic [ldpq_pkg::AMT_W-1:0]   amt_ff, amt_in;
   logic [ldpq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                arrcnt_ff, arrcnt_in;
   logic [HW-1:0]                pos_ff, pos_in;
   slot_type                     mov_ff, mov_in;
   slot_type                     top_ff, top_in;
   logic [EW-1:0]                clr_ff, clr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_empty_ff, rsp_empty_in;
   logic [ldpq_pkg::ID_W-1:0]    rsp_top_ff, rsp_top_in;
   logic [ldpq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // memory ports
   logic           e_we;
   logic [EW-1:0]  e_waddr, e_raddr;
   logic [EDW-1:0] e_wdata, e_rdata;
   logic           h_we;
   logic [HW-1:0]  h_waddr, h_raddr0, h_raddr1;
   logic [SDW-1:0] h_wdata, h_rdata0, h_rdata1;

   ldpq_entry_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(EDW), .ADDR_W(EW)) u_entry_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata)
   );

   ldpq_heap_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(SDW), .ADDR_W(HW)) u_heap_ram (
      .clock  (clock),
      .we     (h_we),
      .waddr  (h_waddr),
      .wdata  (h_wdata),
      .raddr0 (h_raddr0),
      .raddr1 (h_raddr1),
      .rdata0 (h_rdata0),
      .rdata1 (h_rdata1)
   );

   entry_type     ent;
   slot_type      lch, rch, best;
   logic [SW-1:0] sum;
   logic [PB-1:0] prio_new;
   logic [ldpq_pkg::AMT_W-1:0] add;
   logic [CW-1:0] l_wide;
   logic [CW:0]   r_wide;
   logic          l_valid, r_valid, take_l, take_r;
   logic          req_fire, in_range;

   assign ent = entry_type'(e_rdata);
   assign lch = slot_type'(h_rdata0);
   assign rch = slot_type'(h_rdata1);

   // saturating priority update
   always_comb begin
      add = (op_ff == ldpq_pkg::OP_RETIRE) ? ldpq_pkg::AMT_W'(ldpq_pkg::RETIRE_ADD) : amt_ff;
      if (op_ff == ldpq_pkg::OP_ARRIVE) begin
         sum = SW'(amt_ff);
      end else begin
         sum = SW'(ent.prio) + SW'(add);
      end
      prio_new = (sum > SW'(PRIO_MAX)) ? PB'(PRIO_MAX) : PB'(sum);
   end

   // sift-down child selection
   always_comb begin
      l_wide  = {pos_ff, 1'b1};
      r_wide  = (CW+1)'(l_wide) + (CW+1)'(1);
      l_valid = (CW+1)'(l_wide) < (CW+1)'(count_ff);
      r_valid = r_wide < (CW+1)'(count_ff);
      take_l  = l_valid && ranks_below(mov_ff, lch);
      best    = take_l ? lch : mov_ff;
      take_r  = r_valid && ranks_below(best, rch);
   end

   assign req_fire = req_if.valid && req_if.ready;
   assign in_range = int'(req_if.entry_id) < MAX_ENTRIES;
   assign req_if.ready = (state_ff == S_IDLE);

   // sequencer next state and memory control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      amt_in        = amt_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      arrcnt_in     = arrcnt_ff;
      pos_in        = pos_ff;
      mov_in        = mov_ff;
      top_in        = top_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_empty_in  = rsp_empty_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_status_in = rsp_status_ff;
      e_we     = 1'b0;
      e_waddr  = id_ff;
      e_wdata  = '0;
      e_raddr  = EW'(req_if.entry_id);
      h_we     = 1'b0;
      h_waddr  = pos_ff;
      h_wdata  = mov_ff;
      h_raddr0 = (pos_ff - HW'(1)) >> 1;
      h_raddr1 = HW'(r_wide);

      case (state_ff)
         S_CLEAR: begin
            e_we    = 1'b1;
            e_waddr = clr_ff;
            clr_in  = clr_ff + EW'(1);
            if (clr_ff == EW'(MAX_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_if.op;
               id_in     = EW'(req_if.entry_id);
               amt_in    = req_if.amount;
               status_in = ldpq_pkg::ST_OK;
               if (req_if.op == ldpq_pkg::OP_QUERY) begin
                  state_in = S_CLEAN;
               end else if (!in_range) begin
                  status_in = ldpq_pkg::ST_UNKNOWN;
                  state_in  = S_CLEAN;
               end else begin
                  state_in = S_ECHK;
               end
            end
         end
         S_ECHK: begin
            if (op_ff == ldpq_pkg::OP_ARRIVE && ent.present) begin
               status_in = ldpq_pkg::ST_DUPLICATE;
               state_in  = S_CLEAN;
            end else if (op_ff != ldpq_pkg::OP_ARRIVE && !ent.present) begin
               status_in = ldpq_pkg::ST_UNKNOWN;
               state_in  = S_CLEAN;
            end else begin
               mov_in.prio = prio_new;
               mov_in.id   = id_ff;
               if (op_ff == ldpq_pkg::OP_ARRIVE) begin
                  mov_in.arr = arrcnt_ff;
                  arrcnt_in  = arrcnt_ff + AW'(1);
               end else begin
                  mov_in.arr = ent.arr;
               end
               e_we    = 1'b1;
               e_wdata = {1'b1, prio_new, mov_in.arr};
               if (count_ff >= CW'(HEAP_DEPTH)) begin
                  status_in = ldpq_pkg::ST_FULL;
                  state_in  = S_CLEAN;
               end else begin
                  pos_in   = HW'(count_ff);
                  count_in = count_ff + CW'(1);
                  state_in = S_PUSH_RD;
               end
            end
         end
         // sift up: hole at pos, new snapshot held in mov
         S_PUSH_RD: begin
            if (pos_ff == '0) begin
               h_we     = 1'b1;
               state_in = S_CLEAN;
            end else begin
               state_in = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            h_we = 1'b1;
            if (ranks_below(lch, mov_ff)) begin
               h_wdata  = lch;
               pos_in   = (pos_ff - HW'(1)) >> 1;
               state_in = S_PUSH_RD;
            end else begin
               state_in = S_CLEAN;
            end
         end
         // cleanup: read the top and its entry record
         S_CLEAN: begin
            h_raddr0 = '0;
            state_in = (count_ff == '0) ? S_RESP : S_CL_TOP;
         end
         S_CL_TOP: begin
            top_in   = lch;
            e_raddr  = lch.id;
            state_in = S_CL_CHK;
         end
         S_CL_CHK: begin
            if (ent.prio > PB'(ldpq_pkg::LIVE_LIMIT)) begin
               count_in = count_ff - CW'(1);
               h_raddr0 = HW'(count_ff - CW'(1));
               pos_in   = '0;
               state_in = (count_ff == CW'(1)) ? S_CLEAN : S_POP_LAST;
            end else begin
               state_in = S_RESP;
            end
         end
         S_POP_LAST: begin
            mov_in   = lch;
            state_in = S_POP_RD;
         end
         // sift down: read both children of the hole
         S_POP_RD: begin
            h_raddr0 = HW'(l_wide);
            state_in = S_POP_CMP;
         end
         S_POP_CMP: begin
            h_we = 1'b1;
            if (take_r) begin
               h_wdata  = rch;
               pos_in   = HW'(r_wide);
               state_in = S_POP_RD;
            end else if (take_l) begin
               h_wdata  = lch;
               pos_in   = HW'(l_wide);
               state_in = S_POP_RD;
            end else begin
               state_in = S_CLEAN;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_empty_in  = (count_ff == '0);
               rsp_top_in    = (count_ff == '0) ? '0 : ldpq_pkg::ID_W'(top_ff.id);
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         count_ff     <= '0;
         arrcnt_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         arrcnt_ff    <= arrcnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      amt_ff        <= amt_in;
      status_ff     <= status_in;
      pos_ff        <= pos_in;
      mov_ff        <= mov_in;
      top_ff        <= top_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.is_empty  = rsp_empty_ff;
   assign rsp_if.top_entry = rsp_top_ff;
   assign rsp_if.status    = rsp_status_ff;

   // checks
   `LDPQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(HEAP_DEPTH))
   `LDPQ_ASSERT_IMP(a_arrival_bound, clock, reset, 1'b1, arrcnt_ff <= AW'(MAX_ENTRIES))
   `LDPQ_ASSERT_NXT(a_accept_busy, clock, reset, req_fire, state_ff != S_IDLE)

endmodule

@@ dv/tb_lazy_delete_priority_queue_unit.sv @@
// Testbench for the lazy-deletion priority queue: directed and random requests
// checked against a heap predictor kept here. Depends on ldpq_pkg and ldpq_if.
`timescale 1ns / 1ps

module tb_lazy_delete_priority_queue_unit;

   localparam int NUM_IDS    = ldpq_pkg::MAX_ENTRIES_DEF;
   localparam int HEAP_SLOTS = ldpq_pkg::HEAP_DEPTH_DEF;
   localparam int PRIO_TOP   = (1 << ldpq_pkg::PRIORITY_BITS_DEF) - 1;
   localparam int FULL_ID    = 1000;   // kept aside for the heap-full test
   localparam int SETTLE     = 80;

   typedef struct {
      int unsigned prio;
      int unsigned arr;
      int unsigned id;
   } snapshot_type;

   typedef struct {
      logic                          is_empty;
      logic [ldpq_pkg::ID_W-1:0]     top_entry;
      ldpq_pkg::status_type          status;
   } top_report_type;

   logic clock;
   logic reset;

   ldpq_req_if req_if ();
   ldpq_rsp_if rsp_if ();

   lazy_delete_priority_queue_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // predictor state
   bit           q_present [NUM_IDS];
   int unsigned  q_prio    [NUM_IDS];
   int unsigned  q_arrival [NUM_IDS];
   snapshot_type q_heap    [HEAP_SLOTS];
   int unsigned  q_count;
   int unsigned  q_arrival_ctr;

   top_report_type pending_tops[$];
   int             error_count;
   int             send_idle_pct;
   int             stall_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // overall limit
   initial begin
      #40ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic bit ranks_lower(snapshot_type a, snapshot_type b);
      if (a.prio == b.prio) return a.arr > b.arr;
      return a.prio < b.prio;
   endfunction

   function automatic bit heap_insert(int unsigned id);
      int unsigned  i;
      snapshot_type t;
      if (q_count >= HEAP_SLOTS) return 1'b0;
      i = q_count;
      q_count++;
      q_heap[i] = '{q_prio[id], q_arrival[id], id};
      while (i != 0 && ranks_lower(q_heap[(i - 1) / 2], q_heap[i])) begin
         t = q_heap[i];
         q_heap[i] = q_heap[(i - 1) / 2];
         q_heap[(i - 1) / 2] = t;
         i = (i - 1) / 2;
      end
      return 1'b1;
   endfunction

   function automatic void heap_remove_top();
      int unsigned  i, l, r, best;
      snapshot_type t;
      if (q_count == 0) return;
      q_count--;
      if (q_count == 0) return;
      q_heap[0] = q_heap[q_count];
      i = 0;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         best = i;
         if (l < q_count && ranks_lower(q_heap[best], q_heap[l])) best = l;
         if (r < q_count && ranks_lower(q_heap[best], q_heap[r])) best = r;
         if (best == i) break;
         t = q_heap[i];
         q_heap[i] = q_heap[best];
         q_heap[best] = t;
         i = best;
      end
   endfunction

   // apply one request to the predictor and return the expected report
   function automatic top_report_type predict_top(ldpq_pkg::op_type op, int unsigned id,
                                                  int unsigned amt);
      top_report_type rep;
      int unsigned    sum;
      rep.status = ldpq_pkg::ST_OK;
      if (op == ldpq_pkg::OP_ARRIVE) begin
         if (q_present[id]) rep.status = ldpq_pkg::ST_DUPLICATE;
         else begin
            q_present[id] = 1'b1;
            q_prio[id] = (amt > PRIO_TOP) ? PRIO_TOP : amt;
            q_arrival[id] = q_arrival_ctr;
            q_arrival_ctr = (q_arrival_ctr + 1) & 32'h1F_FFFF;
            if (!heap_insert(id)) rep.status = ldpq_pkg::ST_FULL;
         end
      end else if (op != ldpq_pkg::OP_QUERY) begin
         if (!q_present[id]) rep.status = ldpq_pkg::ST_UNKNOWN;
         else begin
            sum = q_prio[id] + ((op == ldpq_pkg::OP_INCREASE) ? amt : ldpq_pkg::RETIRE_ADD);
            q_prio[id] = (sum > PRIO_TOP) ? PRIO_TOP : sum;
            if (!heap_insert(id)) rep.status = ldpq_pkg::ST_FULL;
         end
      end
      // drop dead tops
      while (q_count != 0 && q_prio[q_heap[0].id] > ldpq_pkg::LIVE_LIMIT) heap_remove_top();
      rep.is_empty  = (q_count == 0);
      rep.top_entry = (q_count == 0) ? '0 : q_heap[0].id[ldpq_pkg::ID_W-1:0];
      return rep;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // send one request; prediction made at the accepting edge
   task automatic send_request(ldpq_pkg::op_type op, int unsigned id, int unsigned amt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.entry_id <= id[ldpq_pkg::ID_W-1:0];
      req_if.amount   <= amt[ldpq_pkg::AMT_W-1:0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_tops.push_back(predict_top(op, id, amt));
   endtask

   // hold off until every response is in
   task automatic drain_responses();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_tops.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // receiver stalls at random
   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else       rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // response check
   always @(posedge clock) begin
      top_report_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_tops.size() == 0) begin
            report_mismatch("unexpected response count", 1, 0);
         end else begin
            want = pending_tops.pop_front();
            if (rsp_if.is_empty !== want.is_empty)
               report_mismatch("is_empty", rsp_if.is_empty, want.is_empty);
            if (rsp_if.top_entry !== want.top_entry)
               report_mismatch("top_entry", rsp_if.top_entry, want.top_entry);
            if (rsp_if.status !== want.status)
               report_mismatch("status", rsp_if.status, want.status);
         end
      end
   end

   // special cases and field extremes
   task automatic test_directed();
      send_request(ldpq_pkg::OP_QUERY, 0, 0);          // empty queue
      send_request(ldpq_pkg::OP_INCREASE, 5, 3);       // never arrived
      send_request(ldpq_pkg::OP_RETIRE, 1023, 0);      // never arrived
      send_request(ldpq_pkg::OP_ARRIVE, 0, 0);
      send_request(ldpq_pkg::OP_ARRIVE, 1023, 255);    // dead on arrival, popped
      send_request(ldpq_pkg::OP_ARRIVE, 0, 7);         // duplicate
      send_request(ldpq_pkg::OP_ARRIVE, 682, 40);
      send_request(ldpq_pkg::OP_ARRIVE, 341, 40);      // tie: earlier arrival stays on top
      send_request(ldpq_pkg::OP_INCREASE, 341, 1);
      send_request(ldpq_pkg::OP_INCREASE, 0, 0);
      send_request(ldpq_pkg::OP_RETIRE, 341, 170);
      send_request(ldpq_pkg::OP_INCREASE, 1023, 255);  // saturates
      send_request(ldpq_pkg::OP_INCREASE, 682, 255);
      send_request(ldpq_pkg::OP_QUERY, 1023, 255);
      send_request(ldpq_pkg::OP_ARRIVE, 512, 100);     // exactly at the live limit
      send_request(ldpq_pkg::OP_ARRIVE, 511, 101);
      send_request(ldpq_pkg::OP_RETIRE, 0, 85);
      send_request(ldpq_pkg::OP_RETIRE, 512, 0);
      send_request(ldpq_pkg::OP_QUERY, 0, 0);
      drain_responses();
   endtask

   function automatic int unsigned pick_id(int unsigned want_present);
      int unsigned id;
      repeat (40) begin
         id = (want_present && $urandom_range(3) != 0) ? $urandom_range(63)
                                                       : $urandom_range(NUM_IDS - 1);
         if (id != FULL_ID && q_present[id] == want_present) return id;
      end
      return (id == FULL_ID) ? 1 : id;
   endfunction

   // random mix, mostly on arrived entries
   task automatic test_random(int n);
      int unsigned r, amt;
      repeat (n) begin
         r   = $urandom_range(99);
         amt = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(30);
         if (r < 30)      send_request(ldpq_pkg::OP_ARRIVE, pick_id(0), amt);
         else if (r < 62) send_request(ldpq_pkg::OP_INCREASE, pick_id(1), amt);
         else if (r < 77) send_request(ldpq_pkg::OP_RETIRE, pick_id(1), $urandom_range(255));
         else if (r < 85) send_request(ldpq_pkg::OP_QUERY, $urandom_range(1023),
                                       $urandom_range(255));
         else if (r < 92) send_request(ldpq_pkg::OP_ARRIVE, pick_id(1), amt);
         else send_request(ldpq_pkg::op_type'($urandom_range(2)), pick_id(0), amt);
      end
   endtask

   // fill the heap with live snapshots until pushes are dropped
   task automatic test_heap_full();
      send_request(ldpq_pkg::OP_ARRIVE, FULL_ID, 0);
      while (q_count < HEAP_SLOTS) send_request(ldpq_pkg::OP_INCREASE, FULL_ID, 0);
      send_request(ldpq_pkg::OP_INCREASE, FULL_ID, 0);
      send_request(ldpq_pkg::OP_ARRIVE, pick_id(0), 5);
      send_request(ldpq_pkg::OP_RETIRE, FULL_ID, 0);
      send_request(ldpq_pkg::OP_QUERY, 0, 0);
      drain_responses();
   endtask

   initial begin
      error_count     = 0;
      send_idle_pct   = 37;
      stall_pct       = 56;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.op       = ldpq_pkg::OP_QUERY;
      req_if.entry_id = '0;
      req_if.amount   = '0;
      q_count         = 0;
      q_arrival_ctr   = 0;
      foreach (q_present[i]) begin
         q_present[i] = 1'b0;
         q_prio[i]    = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(350);
      drain_responses();
      send_idle_pct = 56;
      stall_pct     = 37;
      test_random(350);
      drain_responses();
      send_idle_pct = 0;
      stall_pct     = 0;
      test_random(330);
      drain_responses();
      test_heap_full();

      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
